// ===== hdl/polyphase_fir_interpolator_q15_top_defines.svh =====
// Assertion macros shared by the interpolator RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef POLYPHASE_FIR_INTERPOLATOR_Q15_TOP_DEFINES_SVH
`define POLYPHASE_FIR_INTERPOLATOR_Q15_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PFIQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("interpolator check failed");

// Next-cycle implication, checked outside reset.
`define PFIQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("interpolator check failed");

`endif

// ===== hdl/pfiq15_pkg.sv =====
// Shared types and constants of the Q15 polyphase interpolator.
// Used by the multiply-accumulate unit, the top level and the testbench; no dependencies.
package pfiq15_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = 32;
    localparam int FRAC_BITS  = 15;
    localparam int COEF_AW    = 8;
    localparam int COEF_DEPTH = 256;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_W      = 6;
    localparam int INTERP_W   = 4;

    // Item kinds carried in the input tuser.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_IDX_INTERP = 1'b0;
    localparam logic CFG_IDX_PHASE  = 1'b1;

    // Saturation limits of the output.
    localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

    // Per-tap control travelling with an operand pair into the MAC.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

// ===== hdl/pfiq15_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pfiq15_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== hdl/pfiq15_mac.sv =====
// Shared multiply-accumulate unit with output shift and saturation.
// Depends on pfiq15_pkg for the control struct and widths.
module pfiq15_mac
    import pfiq15_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_ctl                   i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_a,
    input  logic signed [SAMPLE_W-1:0] i_b,
    output logic                       o_done,
    output logic [SAMPLE_W-1:0]        o_result
);

    logic signed [ACC_W-1:0] r_prod;
    t_mac_ctl                r_p_ctl;
    logic [ACC_W-1:0]        r_acc;
    logic                    r_done;
    logic [ACC_W-1:0]        acc_base;

    // Product stage.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (!i_rst_n) begin
            r_p_ctl <= '0;
        end else begin
            r_p_ctl <= i_ctl;
        end
    end

    // The first tap of a run restarts the sum.
    assign acc_base = r_p_ctl.first ? '0 : r_acc;

    // Wrapping accumulate stage.
    always_ff @(posedge i_clk) begin
        if (r_p_ctl.valid) begin
            r_acc <= acc_base + unsigned'(r_prod);
        end
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_p_ctl.valid && r_p_ctl.last;
        end
    end

    // Arithmetic shift right by the fraction width, then saturate to 16 bits.
    // The shifted value fits when the two top accumulator bits agree.
    always_comb begin
        if (r_acc[ACC_W-1] == r_acc[ACC_W-2]) begin
            o_result = r_acc[ACC_W-2:FRAC_BITS];
        end else if (r_acc[ACC_W-1]) begin
            o_result = SAT_NEG;
        end else begin
            o_result = SAT_POS;
        end
    end

    assign o_done = r_done;

endmodule

// ===== hdl/polyphase_fir_interpolator_q15_top.sv =====
// Q15 polyphase FIR interpolator. A coefficient write item (tuser high) goes into the
// coefficient memory and gives no output. A sample item (tuser low) is written into a circular
// delay line and then yields interp_factor outputs, the last one flagged with tlast; each output
// is the sum of phase_len products of delay samples and coefficients, shifted right by 15 and
// saturated. All products go through one multiply-accumulate unit, one tap per cycle, so a sample
// item keeps the input side busy until its last output moves to the output register: per output,
// phase_len reads of the delay and coefficient memories, then the memory read, product and
// accumulate registers. The finished output waits in its own register, so the next item is taken
// while it is still pending. Coefficients must be written before the samples that use them.
// Depends on pfiq15_pkg, pfiq15_ram, pfiq15_mac and the project assertion macros.
`include "polyphase_fir_interpolator_q15_top_defines.svh"

module polyphase_fir_interpolator_q15_top
    import pfiq15_pkg::*;
#(
    parameter int MAX_INTERP    = 8,
    parameter int MAX_PHASE_LEN = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration writes.
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: sample [15:0], coef_index [23:16], coef_value [39:24]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: cmd
    input  logic                  s_axis_tuser,
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: out_sample [15:0]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam int DW = (MAX_PHASE_LEN > 1) ? $clog2(MAX_PHASE_LEN) : 1;
    localparam int PW = $clog2(MAX_PHASE_LEN + 1);
    localparam int IW = $clog2(MAX_INTERP + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } t_state;

    t_state                  r_state;
    logic [INTERP_W-1:0]     r_interp;
    logic [CFG_W-1:0]        r_phase;
    logic [DW-1:0]           r_wpos;
    logic [MAX_PHASE_LEN-1:0] r_dvalid;
    logic [IW-1:0]           r_lf;
    logic [PW-1:0]           r_pl;
    logic [IW-1:0]           r_run;
    logic [PW-1:0]           r_k;
    logic [DW-1:0]           r_start;
    logic [DW-1:0]           r_slot;
    logic [COEF_AW-1:0]      r_caddr;
    logic                    r_dv;
    t_mac_ctl                r_rd_ctl;
    logic                    r_res;
    logic                    r_out_v;
    logic [SAMPLE_W-1:0]     r_out_data;
    logic                    r_out_last;

    logic                    s_fire;
    logic                    sample_fire;
    logic                    coef_fire;
    logic [IW-1:0]           lf_c;
    logic [PW-1:0]           pl_c;
    logic [DW:0]             back;
    logic [DW-1:0]           start_c;
    logic [DW-1:0]           slot_inc;
    logic [DW-1:0]           wpos_inc;
    logic                    tap_last;
    logic                    out_load;
    logic [SAMPLE_W-1:0]     delay_q;
    logic [SAMPLE_W-1:0]     coef_q;
    logic signed [SAMPLE_W-1:0] mac_a;
    logic                    mac_done;
    logic [SAMPLE_W-1:0]     mac_result;

    // Input transfers.
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign sample_fire   = s_fire && (s_axis_tuser == CMD_SAMPLE);
    assign coef_fire     = s_fire && (s_axis_tuser == CMD_COEF);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp <= INTERP_W'(4);
            r_phase  <= CFG_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_INTERP: r_interp <= i_cfg_wdata[INTERP_W-1:0];
                CFG_IDX_PHASE:  r_phase  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Out-of-range factor and length saturate to the supported range.
    always_comb begin
        if (r_interp == '0) begin
            lf_c = IW'(1);
        end else if (int'(r_interp) > MAX_INTERP) begin
            lf_c = IW'(MAX_INTERP);
        end else begin
            lf_c = IW'(r_interp);
        end
        if (r_phase == '0) begin
            pl_c = PW'(1);
        end else if (int'(r_phase) > MAX_PHASE_LEN) begin
            pl_c = PW'(MAX_PHASE_LEN);
        end else begin
            pl_c = PW'(r_phase);
        end
    end

    // Oldest slot of the window that ends at the newly written sample.
    always_comb begin
        back = (DW + 1)'(pl_c - PW'(1));
        if ({1'b0, r_wpos} >= back) begin
            start_c = DW'({1'b0, r_wpos} - back);
        end else begin
            start_c = DW'({1'b0, r_wpos} + (DW + 1)'(MAX_PHASE_LEN) - back);
        end
    end

    // Circular increments of the delay line pointers.
    assign slot_inc = (r_slot == DW'(MAX_PHASE_LEN - 1)) ? '0 : r_slot + DW'(1);
    assign wpos_inc = (r_wpos == DW'(MAX_PHASE_LEN - 1)) ? '0 : r_wpos + DW'(1);
    assign tap_last = (r_k == r_pl - PW'(1));

    // A finished sum moves to the output register once that register is free.
    assign out_load = (r_state == S_WAIT) && (mac_done || r_res)
                      && (!r_out_v || m_axis_tready);

    // Delay line valid bits: slots never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= '0;
            r_wpos   <= '0;
        end else if (sample_fire) begin
            r_dvalid[r_wpos] <= 1'b1;
            r_wpos           <= wpos_inc;
        end
    end

    // Sequencer: one tap read per cycle in S_RUN, then wait for the sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_ctl <= '0;
            r_res    <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            // The output register refills from a finished sum or empties on a transfer.
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_rd_ctl <= '0;
                    if (sample_fire) begin
                        r_lf    <= lf_c;
                        r_pl    <= pl_c;
                        r_run   <= lf_c;
                        r_start <= start_c;
                        r_slot  <= start_c;
                        r_caddr <= COEF_AW'(lf_c) - COEF_AW'(1);
                        r_k     <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    // Control fields in order: valid, first, last.
                    r_rd_ctl <= {1'b1, (r_k == '0), tap_last};
                    r_dv     <= r_dvalid[r_slot];
                    r_slot   <= slot_inc;
                    r_caddr  <= r_caddr + COEF_AW'(r_lf);
                    r_k      <= r_k + PW'(1);
                    if (tap_last) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_rd_ctl <= '0;
                    if (out_load) begin
                        r_out_data <= mac_result;
                        r_out_last <= (r_run == IW'(1));
                        r_res      <= 1'b0;
                        if (r_run == IW'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            // Next branch starts at coefficient (run - 2).
                            r_run   <= r_run - IW'(1);
                            r_slot  <= r_start;
                            r_caddr <= COEF_AW'(r_run) - COEF_AW'(2);
                            r_k     <= '0;
                            r_state <= S_RUN;
                        end
                    end else if (mac_done) begin
                        r_res <= 1'b1;
                    end
                end
                default: begin
                    r_rd_ctl <= '0;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    // Delay line storage.
    pfiq15_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_PHASE_LEN)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (sample_fire),
        .i_waddr (r_wpos),
        .i_wdata (s_axis_tdata[SAMPLE_W-1:0]),
        .i_raddr (r_slot),
        .o_rdata (delay_q)
    );

    // Coefficient storage.
    pfiq15_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_fire),
        .i_waddr (s_axis_tdata[23:16]),
        .i_wdata (s_axis_tdata[39:24]),
        .i_raddr (r_caddr),
        .o_rdata (coef_q)
    );

    assign mac_a = r_dv ? signed'(delay_q) : '0;

    // Shared multiply-accumulate unit.
    pfiq15_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_rd_ctl),
        .i_a      (mac_a),
        .i_b      (signed'(coef_q)),
        .o_done   (mac_done),
        .o_result (mac_result)
    );

    // Output register.
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // A sample transfer starts a run and blocks further input.
    `PFIQ_ASSERT_NXT(a_busy_after_sample, sample_fire, !s_axis_tready)
    // Sums complete only while the sequencer waits for them.
    `PFIQ_ASSERT_IMP(a_done_in_wait, mac_done, r_state == S_WAIT)
    // A pending output is never overwritten.
    `PFIQ_ASSERT_IMP(a_no_overwrite, out_load, !r_out_v || m_axis_tready)
    // The tap counter stays inside the branch length.
    `PFIQ_ASSERT_IMP(a_tap_bound, r_state == S_RUN, r_k < r_pl)

endmodule

// ===== tb/pfiq15_stream_checker.sv =====
// Scoreboard for the Q15 polyphase interpolator: watches the config port and both streams,
// predicts every output transfer and compares it with what the block delivers.
// Depends on pfiq15_pkg.
`timescale 1ns / 100ps

module pfiq15_stream_checker
    import pfiq15_pkg::*;
#(
    parameter int MAX_INTERP    = 8,
    parameter int MAX_PHASE_LEN = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    // tdata: sample [15:0], coef_index [23:16], coef_value [39:24]
    input  logic [S_TDATA_W-1:0]  i_in_data,
    // tuser: cmd
    input  logic                  i_in_user,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    // tdata: out_sample [15:0]
    input  logic [M_TDATA_W-1:0]  i_out_data,
    input  logic                  i_out_last,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [3:0] RST_INTERP = 4'd4;
    localparam logic [5:0] RST_PHASE  = 6'd16;

    typedef struct packed {
        logic [SAMPLE_W-1:0] out_sample;
        logic                last;
    } t_branch_out;

    // Shadow copy of the block state.
    logic [3:0]          interp_reg;
    logic [5:0]          phase_reg;
    logic [SAMPLE_W-1:0] taps [MAX_PHASE_LEN];
    int                  wr_pos;
    logic [SAMPLE_W-1:0] coefs [COEF_DEPTH];

    t_branch_out expected_outs [$];

    // Floor shift by the fraction width, then clamp to 16 bits.
    function automatic logic [SAMPLE_W-1:0] sat_q15(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] q;
        q = acc >>> FRAC_BITS;
        if (q > 32767) return SAT_POS;
        if (q < -32768) return SAT_NEG;
        return q[SAMPLE_W-1:0];
    endfunction

    // Push a sample into the delay line and queue one output per polyphase branch.
    task automatic predict_branch_outputs(input logic [SAMPLE_W-1:0] smp);
        int lf;
        int pl;
        int br;
        int k;
        int newest;
        int slot;
        logic [COEF_AW-1:0] ci;
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] prod;
        t_branch_out res;
        newest = wr_pos;
        taps[newest] = smp;
        wr_pos = (newest + 1) % MAX_PHASE_LEN;
        // Out-of-range settings saturate into the legal range.
        lf = (interp_reg == 0) ? 1 : ((interp_reg > MAX_INTERP) ? MAX_INTERP : int'(interp_reg));
        pl = (phase_reg == 0) ? 1 :
             ((phase_reg > MAX_PHASE_LEN) ? MAX_PHASE_LEN : int'(phase_reg));
        for (br = lf; br >= 1; br--) begin
            acc = '0;
            for (k = 0; k < pl; k++) begin
                slot = (newest + MAX_PHASE_LEN - (pl - 1 - k)) % MAX_PHASE_LEN;
                ci   = COEF_AW'((br - 1) + k * lf);
                prod = $signed(taps[slot]) * $signed(coefs[ci]);
                acc  = acc + prod;
            end
            res.out_sample = sat_q15(acc);
            res.last       = (br == 1);
            expected_outs.push_back(res);
        end
    endtask

    // Track configuration and inputs first, so a result in the cycle of its input still matches.
    always @(posedge i_clk) begin : watch
        t_branch_out want;
        if (!i_rst_n) begin
            interp_reg   = RST_INTERP;
            phase_reg    = RST_PHASE;
            wr_pos       = 0;
            o_fail_count = 0;
            for (int n = 0; n < MAX_PHASE_LEN; n++) taps[n] = '0;
            for (int n = 0; n < COEF_DEPTH; n++) coefs[n] = '0;
            expected_outs.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_INTERP) interp_reg = i_cfg_wdata[INTERP_W-1:0];
                else phase_reg = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_user == CMD_COEF) coefs[i_in_data[23:16]] = i_in_data[39:24];
                else predict_branch_outputs(i_in_data[15:0]);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_outs.size() == 0) begin
                    $error("out_sample: no transfer expected, actual %0d", $signed(i_out_data));
                    o_fail_count++;
                end else begin
                    want = expected_outs.pop_front();
                    if (i_out_data !== want.out_sample) begin
                        $error("out_sample mismatch: expected %0d, actual %0d",
                               $signed(want.out_sample), $signed(i_out_data));
                        o_fail_count++;
                    end
                    if (i_out_last !== want.last) begin
                        $error("last mismatch: expected %0b, actual %0b",
                               want.last, i_out_last);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_outs.size();
    end

endmodule

// ===== tb/polyphase_fir_interpolator_q15_top_tb.sv =====
// Top of the interpolator testbench: clock, reset, directed and random stimulus, verdict.
// Depends on pfiq15_pkg, the interpolator RTL and pfiq15_stream_checker.
`timescale 1ns / 100ps

module polyphase_fir_interpolator_q15_top_tb;
    import pfiq15_pkg::*;

    localparam int SETTLE_CYCLES = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 30;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_idx   = CFG_IDX_INTERP;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = CMD_SAMPLE;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int fail_count;
    int pending;
    int send_idle_pct = 35;
    int recv_idle_pct = 80;
    int stall_cycles  = 0;

    polyphase_fir_interpolator_q15_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast)
    );

    pfiq15_stream_checker scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_in_user    (s_tuser),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_out_last   (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock.
    initial begin
        forever #6 clk = ~clk;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Count cycles in which neither stream completes a transfer.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("FAIL polyphase_fir_interpolator_q15_top");
        $finish;
    end

    // Offer one item, with random idle cycles ahead of it; returns on a falling edge.
    task automatic push_item(input logic cmd, input logic [S_TDATA_W-1:0] payload);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= payload;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Sample item; the unused coefficient fields carry noise.
    task automatic push_sample(input logic [SAMPLE_W-1:0] smp);
        logic [23:0] noise;
        noise = 24'($urandom);
        push_item(CMD_SAMPLE, {noise, smp});
    endtask

    // Coefficient item; the unused sample field carries noise.
    task automatic push_coef(input logic [COEF_AW-1:0] idx, input logic [SAMPLE_W-1:0] val);
        logic [SAMPLE_W-1:0] noise;
        noise = SAMPLE_W'($urandom);
        push_item(CMD_COEF, {val, idx, noise});
    endtask

    // Wait until every output has arrived and the engine has had time to go quiet.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write both registers on consecutive cycles.
    task automatic set_rates(input logic [CFG_W-1:0] factor, input logic [CFG_W-1:0] taps);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_IDX_INTERP;
        cfg_wdata <= factor;
        @(negedge clk);
        cfg_idx   <= CFG_IDX_PHASE;
        cfg_wdata <= taps;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [S_TDATA_W-1:0] payload;
        logic [CFG_W-1:0] f_sel;
        logic [CFG_W-1:0] p_sel;

        // Reset once, then release it on a falling edge.
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill the whole coefficient memory so no unwritten entry is ever read.
        for (int a = 0; a < COEF_DEPTH; a++) push_coef(COEF_AW'(a), SAMPLE_W'($urandom));

        // Reset settings: extreme samples.
        push_sample(SAT_POS);
        push_sample(SAT_NEG);
        push_sample(16'h0000);
        push_sample(16'hFFFF);

        // One branch, two taps: positive saturation, then a wrapping accumulator.
        settle_idle();
        set_rates(6'd1, 6'd2);
        push_coef(8'd0, SAT_POS);
        push_coef(8'd1, SAT_POS);
        push_sample(SAT_POS);
        push_sample(SAT_POS);
        push_coef(8'd0, SAT_NEG);
        push_coef(8'd1, SAT_NEG);
        push_sample(SAT_NEG);
        push_sample(SAT_NEG);
        push_sample(SAT_POS);

        // Zero in both registers behaves as one branch of one tap.
        settle_idle();
        set_rates(6'd0, 6'd0);
        push_sample(16'h0001);
        push_sample(16'hFFFF);
        push_sample(SAT_POS);

        // All-ones settings clamp to the largest factor and length; the window
        // then reaches slots never written since reset.
        settle_idle();
        set_rates(6'h3F, 6'h3F);
        push_coef(8'd255, SAT_POS);
        push_sample(SAT_NEG);
        push_sample(16'h4000);

        // Random phases over several settings and idle patterns.
        for (int ph = 0; ph < 6; ph++) begin
            settle_idle();
            case (ph / 2)
                0: begin
                    send_idle_pct <= 35;
                    recv_idle_pct <= 80;
                end
                1: begin
                    send_idle_pct <= 80;
                    recv_idle_pct <= 35;
                end
                default: begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            case (ph)
                0: begin
                    f_sel = 6'd8;
                    p_sel = 6'd32;
                end
                1: begin
                    f_sel = 6'd1;
                    p_sel = 6'd1;
                end
                2: begin
                    f_sel = CFG_W'($urandom_range(1, 8));
                    p_sel = CFG_W'($urandom_range(1, 8));
                end
                3: begin
                    f_sel = 6'd2;
                    p_sel = 6'd5;
                end
                4: begin
                    f_sel = CFG_W'($urandom_range(0, 63));
                    p_sel = CFG_W'($urandom_range(0, 63));
                end
                default: begin
                    f_sel = 6'd3;
                    p_sel = 6'd12;
                end
            endcase
            set_rates(f_sel, p_sel);
            repeat (PHASE_ITEMS) begin
                payload = S_TDATA_W'({$urandom, $urandom});
                // Roughly one coefficient rewrite in five; samples sometimes at full scale.
                if ($urandom_range(0, 4) == 0) begin
                    push_item(CMD_COEF, payload);
                end else begin
                    case ($urandom_range(0, 7))
                        0: payload[15:0] = SAT_POS;
                        1: payload[15:0] = SAT_NEG;
                        default: ;
                    endcase
                    push_item(CMD_SAMPLE, payload);
                end
            end
        end

        settle_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("PASS polyphase_fir_interpolator_q15_top");
        end else begin
            $display("FAIL polyphase_fir_interpolator_q15_top");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pfiq15_pkg.sv
hdl/pfiq15_ram.sv
hdl/pfiq15_mac.sv
hdl/polyphase_fir_interpolator_q15_top.sv
tb/pfiq15_stream_checker.sv
tb/polyphase_fir_interpolator_q15_top_tb.sv
